FILE: sv/keypad_matrix_scan_repeat_unit_macros.svh
// Assertion helpers for the keypad scanner
`ifndef KEYPAD_MATRIX_SCAN_REPEAT_UNIT_MACROS_SVH
`define KEYPAD_MATRIX_SCAN_REPEAT_UNIT_MACROS_SVH
`define KMS_ASSERT_IMP(label, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define KMS_ASSERT_NXT(label, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

FILE: sv/kms_pkg.sv
package kms_pkg;
  localparam int Columns = 5;
  localparam int Rows = 7;
  localparam int NKeys = Columns * Rows;
  localparam int LevelBits = 35;
  localparam int KeyW = 6;
  localparam int TickW = 32;
  localparam int QCntW = $clog2(NKeys + 2);

  localparam logic [2:0] CFG_DELAY = 3'd0;
  localparam logic [2:0] CFG_PERIOD = 3'd1;
  localparam logic [2:0] CFG_SYM = 3'd2;
  localparam logic [2:0] CFG_ALT = 3'd3;
  localparam logic [2:0] CFG_SHIFT = 3'd4;
  localparam logic [2:0] CFG_MIC = 3'd5;
  localparam logic [2:0] CFG_BACK = 3'd6;
  localparam logic [2:0] CFG_ENTER = 3'd7;

  localparam logic [1:0] CSET_LOWER = 2'd0;
  localparam logic [1:0] CSET_UPPER = 2'd1;
  localparam logic [1:0] CSET_SYMBOL = 2'd2;

  typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_EMIT} state_t;

  // role matches of one key against the configured indices
  typedef struct packed {
    logic sym;
    logic alt;
    logic lsh;
    logic rsh;
    logic mic;
    logic back;
    logic enter;
  } role_t;

  // what one lane reports for its key in this scan
  typedef struct packed {
    logic  fire;     // press or repeat
    logic  release_k;
    role_t role;
  } lane_res_t;
endpackage

FILE: sv/kms_lane.sv
module kms_lane (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic                      level,
  input  logic [kms_pkg::TickW-1:0] now_tick,
  input  logic [15:0]               delay,
  input  logic [15:0]               period,
  input  kms_pkg::role_t            role,
  output kms_pkg::lane_res_t        res
);
  import kms_pkg::*;

  logic             latched_r;
  logic [TickW-1:0] deadline_r;
  logic             press_new, still;

  assign press_new = level && !latched_r;
  assign still = level && latched_r && (now_tick > deadline_r);

  // per-key latch and deadline; updated once per scan
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latched_r <= 1'b0;
      deadline_r <= '0;
    end else if (start) begin
      if (press_new) begin
        latched_r <= 1'b1;
        deadline_r <= now_tick + TickW'(delay);
      end else if (!level && latched_r) begin
        latched_r <= 1'b0;
        deadline_r <= '0;
      end else if (still) begin
        deadline_r <= deadline_r + TickW'(period);
      end
    end
  end

  always_comb begin
    res.fire = press_new || still;
    res.release_k = !level && latched_r;
    res.role = role;
  end
endmodule

FILE: sv/kms_merge.sv
module kms_merge (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic                     step,
  input  logic [kms_pkg::KeyW-1:0] key,
  input  kms_pkg::lane_res_t       res,
  input  logic                     done,
  output logic                     push,
  output logic                     back_o,
  output logic                     enter_o,
  output logic                     caps_o,
  output logic                     syml_o,
  output logic [1:0]               cset_o
);
  import kms_pkg::*;

  logic [3:0] mod_r, mod_nxt;
  logic       back_r, back_nxt, enter_r, enter_nxt;
  logic       caps_r, syml_r;

  // walk-order role resolution for one key
  always_comb begin
    mod_nxt = mod_r;
    back_nxt = back_r;
    enter_nxt = enter_r;
    push = 1'b0;
    if (start) begin
      back_nxt = 1'b0;
      enter_nxt = 1'b0;
    end else if (step && (res.fire || res.release_k)) begin
      if (res.role.sym) mod_nxt[0] = res.fire;
      else if (res.role.alt) mod_nxt[1] = res.fire;
      else if (res.role.lsh) mod_nxt[2] = res.fire;
      else if (res.role.rsh) mod_nxt[3] = res.fire;
      else if (res.fire) begin
        if (res.role.mic && !mod_r[0]) push = 1'b0;
        else if (res.role.back) back_nxt = 1'b1;
        else if (res.role.enter) enter_nxt = 1'b1;
        else push = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r <= '0;
      back_r <= 1'b0;
      enter_r <= 1'b0;
      caps_r <= 1'b0;
      syml_r <= 1'b0;
    end else begin
      mod_r <= mod_nxt;
      back_r <= back_nxt;
      enter_r <= enter_nxt;
      // lock toggles at the end of the walk, with the last key included
      if (done) begin
        if ((mod_nxt[2] && mod_nxt[3]) || (mod_nxt[1] && (mod_nxt[2] || mod_nxt[3])))
          caps_r <= !caps_r;
        if (mod_nxt[1] && mod_nxt[0]) syml_r <= !syml_r;
      end
    end
  end

  assign back_o = back_r;
  assign enter_o = enter_r;
  assign caps_o = caps_r;
  assign syml_o = syml_r;
  always_comb begin
    if (mod_r[0] || syml_r) cset_o = CSET_SYMBOL;
    else if (mod_r[2] || mod_r[3] || caps_r) cset_o = CSET_UPPER;
    else cset_o = CSET_LOWER;
  end

  // walk index stays inside the key range
  `include "keypad_matrix_scan_repeat_unit_macros.svh"
  `KMS_ASSERT_IMP(a_push_needs_fire, push, res.fire && step)
  `KMS_ASSERT_IMP(a_key_range, step, key < KeyW'(NKeys))
  `KMS_ASSERT_NXT(a_start_clears, start, !back_r && !enter_r)
endmodule

FILE: sv/keypad_matrix_scan_repeat_unit.sv
// Flow: the key lanes update at the accepting edge, then the merge walks the
// 35 keys one per cycle, and the results are emitted after the walk ends.
// A new scan is accepted only in idle, after the last result of the previous
// scan has been taken; the result channel can stall on out_tready.
// Reset: synchronous active-low rst_n clears latches, deadlines, modifiers,
// locks and pending results, and loads the register defaults.
module keypad_matrix_scan_repeat_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // key_levels[34:0], now_tick[66:35], zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // is_character, key_index[6], character_set[2],
                                  // back_event, enter_event, caps_locked,
                                  // symbols_locked, zero pad
  output logic        out_tlast,  // last_of_scan
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import kms_pkg::*;

  logic [15:0]     delay_r, period_r;
  logic [KeyW-1:0] sym_r, alt_r, mic_r, back_r, enter_r;
  logic [11:0]     shift_r;

  state_t state_r, state_nxt;
  logic [NKeys-1:0]   fire_r, rel_r, pmask_r;
  logic [QCntW-1:0]   k_r;
  logic [KeyW-1:0]    head_key;
  logic               lst;
  logic               start, step, done, push;
  lane_res_t          lres [NKeys];
  lane_res_t          cur;
  logic [TickW-1:0]   now_w;
  logic [LevelBits-1:0] lv_in;
  logic back_w, enter_w, caps_w, syml_w;
  logic [1:0] cset_w;
  logic ovalid;

  assign lv_in = in_tdata[LevelBits-1:0];
  assign now_w = in_tdata[LevelBits+TickW-1:LevelBits];
  assign cfg_ready = 1'b1;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r <= 16'd500; period_r <= 16'd100; sym_r <= 6'd0; alt_r <= 6'd1;
      shift_r <= 12'd130; mic_r <= 6'd3; back_r <= 6'd4; enter_r <= 6'd5;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_DELAY:  delay_r <= cfg_data;
        CFG_PERIOD: period_r <= cfg_data;
        CFG_SYM:    sym_r <= cfg_data[KeyW-1:0];
        CFG_ALT:    alt_r <= cfg_data[KeyW-1:0];
        CFG_SHIFT:  shift_r <= cfg_data[11:0];
        CFG_MIC:    mic_r <= cfg_data[KeyW-1:0];
        CFG_BACK:   back_r <= cfg_data[KeyW-1:0];
        CFG_ENTER:  enter_r <= cfg_data[KeyW-1:0];
        default: ;
      endcase
    end
  end

  assign in_tready = (state_r == ST_IDLE);
  assign start = in_tvalid && in_tready;

  // key lanes
  for (genvar g = 0; g < NKeys; g++) begin : g_lane
    role_t rl;
    always_comb begin
      rl.sym = (KeyW'(g) == sym_r);
      rl.alt = (KeyW'(g) == alt_r);
      rl.lsh = (KeyW'(g) == shift_r[5:0]);
      rl.rsh = (KeyW'(g) == shift_r[11:6]);
      rl.mic = (KeyW'(g) == mic_r);
      rl.back = (KeyW'(g) == back_r);
      rl.enter = (KeyW'(g) == enter_r);
    end
    kms_lane u_lane (
      .clk(clk), .rst_n(rst_n), .start(start), .level(lv_in[g]),
      .now_tick(now_w), .delay(delay_r), .period(period_r), .role(rl),
      .res(lres[g])
    );
  end

  // capture what every lane saw in this scan
  always_ff @(posedge clk) begin
    if (start) begin
      for (int i = 0; i < NKeys; i++) begin
        fire_r[i] <= lres[i].fire;
        rel_r[i] <= lres[i].release_k;
      end
    end
  end

  // current walk element; roles re-derived from the config
  always_comb begin
    cur.fire = 1'b0;
    cur.release_k = 1'b0;
    cur.role = '0;
    for (int i = 0; i < NKeys; i++) begin
      if (k_r == QCntW'(i)) begin
        cur.fire = fire_r[i];
        cur.release_k = rel_r[i];
        cur.role = lres[i].role;
      end
    end
  end

  assign step = (state_r == ST_WALK);
  assign done = step && (k_r == QCntW'(NKeys - 1));

  kms_merge u_merge (
    .clk(clk), .rst_n(rst_n), .start(start), .step(step),
    .key(k_r[KeyW-1:0]), .res(cur), .done(done), .push(push),
    .back_o(back_w), .enter_o(enter_w), .caps_o(caps_w), .syml_o(syml_w),
    .cset_o(cset_w)
  );

  // lowest pending character key; walk order is index order
  always_comb begin
    head_key = '0;
    for (int i = NKeys - 1; i >= 0; i--) begin
      if (pmask_r[i]) head_key = KeyW'(i);
    end
  end
  assign lst = (pmask_r == '0);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (start) state_nxt = ST_WALK;
      ST_WALK: if (done) state_nxt = ST_EMIT;
      ST_EMIT: if (ovalid && out_tready && lst) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      k_r <= '0;
      pmask_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (start) begin
        k_r <= '0;
        pmask_r <= '0;
      end else if (step) begin
        k_r <= k_r + 1'b1;
        if (push) pmask_r[k_r[KeyW-1:0]] <= 1'b1;
      end else if (ovalid && out_tready && !lst) begin
        pmask_r[head_key] <= 1'b0;
      end
    end
  end

  // result channel
  assign ovalid = (state_r == ST_EMIT);
  assign out_tvalid = ovalid;
  always_comb begin
    out_tlast = lst;
    out_tdata = '0;
    out_tdata[0] = !lst;
    out_tdata[6:1] = head_key;
    out_tdata[8:7] = lst ? CSET_LOWER : cset_w;
    out_tdata[9] = back_w;
    out_tdata[10] = enter_w;
    out_tdata[11] = caps_w;
    out_tdata[12] = syml_w;
  end

  `include "keypad_matrix_scan_repeat_unit_macros.svh"
  `KMS_ASSERT_IMP(a_idle_empty, state_r == ST_IDLE, pmask_r == '0)
  `KMS_ASSERT_NXT(a_start_walk, start, state_r == ST_WALK && k_r == '0)
  `KMS_ASSERT_IMP(a_no_push_emit, ovalid, !push)
endmodule
